FILE: rtl/ntt_pkg.sv
package ntt_pkg;

    // Payload of one input item
    typedef struct packed {
        logic [7:0] char0;
        logic [7:0] char1;
        logic [7:0] char2;
        logic [7:0] char3;
        logic [7:0] char4;
        logic [7:0] char5;
        logic [2:0] token_length;
        logic       restart;
    } token_t;

    // Payload of one result item
    typedef struct packed {
        logic        tone_on;
        logic [16:0] period_us;
        logic [19:0] frequency_hz;
        logic [23:0] duration_ms;
    } tone_t;

    // Parsed item handed from the front to the back
    typedef struct packed {
        logic        tone_on;
        logic [16:0] period_us;
        logic [7:0]  length;
    } job_t;

    localparam int DIV_W  = 20;
    localparam int DVS_W  = 17;
    localparam int DCNT_W = 5;

    // Request into the shared divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_L1,
        BK_W1,
        BK_L2,
        BK_W2,
        BK_L3,
        BK_W3,
        BK_MUL,
        BK_EMIT
    } back_state_t;

    // Register indexes (address bit 2)
    localparam logic REG_BPM = 1'b0;
    localparam logic REG_TPB = 1'b1;

    localparam logic [15:0] BPM_RESET = 16'd120;
    localparam logic [15:0] TPB_RESET = 16'd4;
    localparam logic [3:0]  OCT_RESET = 4'd4;
    localparam logic [7:0]  LEN_RESET = 8'd4;

    localparam logic [2:0] TOKEN_MAX = 3'd6;
    localparam logic [7:0] CH_SHARP  = 8'h23;
    localparam logic [7:0] CH_FLAT   = 8'h62;
    localparam logic [7:0] CH_COLON  = 8'h3a;

    localparam logic [DIV_W-1:0] MS_PER_MIN = 20'd60000;
    localparam logic [DIV_W-1:0] US_PER_S   = 20'd1000000;
    localparam logic [23:0]      ARTIC_MS   = 24'd10;
    localparam logic [23:0]      SHORT_MS   = 24'd20;

    // Octave 4 periods in us, A..G; last slot unused
    localparam logic [11:0] NATURAL_US [8] = '{
        12'd2273, 12'd2025, 12'd3822, 12'd3405, 12'd3034, 12'd2863, 12'd2551, 12'd0
    };
    localparam logic [11:0] SHARP_US [8] = '{
        12'd2145, 12'd0, 12'd3608, 12'd3214, 12'd0, 12'd2703, 12'd2408, 12'd0
    };

endpackage

FILE: rtl/ntt_front.sv
module ntt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            token_valid,
    output logic            token_ready,
    input  ntt_pkg::token_t token,
    input  logic            queue_full,
    output logic            push,
    output ntt_pkg::job_t   job
);

    logic [3:0] oct_reg, oct_next;
    logic [7:0] len_reg, len_next;

    logic [2:0]  tok_len;
    logic [3:0]  base_oct;
    logic [7:0]  base_len;
    logic        has_mod, is_flat, cb;
    logic [7:0]  note_raw, note;
    logic [2:0]  pos_a, pos_b, pos_c, pos_d;
    logic [7:0]  b_a, b_b, b_c, b_d;
    logic        oct_here, colon, d1_here, d2_here;
    logic [7:0]  len_two;
    logic [2:0]  idx;
    logic [11:0] base_us;
    logic signed [5:0] shift;
    logic [5:0]  neg_shift;
    logic [16:0] period;

    function automatic logic [7:0] byte_at(input ntt_pkg::token_t t, input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0: b = t.char0;
            3'd1: b = t.char1;
            3'd2: b = t.char2;
            3'd3: b = t.char3;
            3'd4: b = t.char4;
            3'd5: b = t.char5;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    assign token_ready = !queue_full;
    assign push        = token_valid && token_ready;

    always_comb
    begin
        tok_len  = (token.token_length > ntt_pkg::TOKEN_MAX) ? ntt_pkg::TOKEN_MAX
                                                             : token.token_length;
        base_oct = token.restart ? ntt_pkg::OCT_RESET : oct_reg;
        base_len = token.restart ? ntt_pkg::LEN_RESET : len_reg;

        has_mod  = (3'd1 < tok_len) &&
                   (token.char1 == ntt_pkg::CH_SHARP || token.char1 == ntt_pkg::CH_FLAT);
        is_flat  = has_mod && (token.char1 == ntt_pkg::CH_FLAT);
        note_raw = {3'b000, token.char0[4:0]} - 8'd1;
        if (is_flat)
            note = (note_raw == 8'd0) ? 8'd6 : note_raw - 8'd1;
        else
            note = note_raw;
        cb = is_flat && (note == 8'd1);

        pos_a    = has_mod ? 3'd2 : 3'd1;
        b_a      = byte_at(token, pos_a);
        oct_here = (pos_a < tok_len) && (b_a != ntt_pkg::CH_COLON);
        oct_next = oct_here ? b_a[3:0] : base_oct;

        pos_b   = pos_a + {2'b00, oct_here};
        b_b     = byte_at(token, pos_b);
        colon   = (pos_b < tok_len) && (b_b == ntt_pkg::CH_COLON);
        pos_c   = pos_b + 3'd1;
        b_c     = byte_at(token, pos_c);
        d1_here = colon && (pos_c < tok_len);
        pos_d   = pos_c + 3'd1;
        b_d     = byte_at(token, pos_d);
        d2_here = d1_here && (pos_d < tok_len);
        len_two = ({4'b0000, b_c[3:0]} * 8'd10) + {4'b0000, b_d[3:0]};
        if (d2_here)
            len_next = len_two;
        else if (d1_here)
            len_next = {4'b0000, b_c[3:0]};
        else
            len_next = base_len;

        // Pick the table period, fall back to natural where no sharp exists
        idx = note[2:0];
        if (has_mod && ntt_pkg::SHARP_US[idx] != 12'd0)
            base_us = ntt_pkg::SHARP_US[idx];
        else
            base_us = ntt_pkg::NATURAL_US[idx];

        shift     = $signed({2'b00, oct_next}) - 6'sd4 - (cb ? 6'sd1 : 6'sd0);
        neg_shift = 6'(-shift);
        if (shift >= 0)
            period = {5'b00000, base_us} >> shift[3:0];
        else
            period = {5'b00000, base_us} << neg_shift[2:0];
        if (period == 17'd0)
            period = 17'd1;

        job.tone_on   = (note < 8'd7);
        job.period_us = job.tone_on ? period : 17'd0;
        job.length    = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg <= ntt_pkg::OCT_RESET;
            len_reg <= ntt_pkg::LEN_RESET;
        end
        else if (push)
        begin
            oct_reg <= oct_next;
            len_reg <= len_next;
        end
    end

endmodule

FILE: rtl/ntt_queue.sv
module ntt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ntt_pkg::job_t job_in,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output ntt_pkg::job_t job_out
);

    ntt_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign job_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/ntt_divider.sv
module ntt_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ntt_pkg::div_req_t         req,
    output logic                      done,
    output logic [ntt_pkg::DIV_W-1:0] quotient
);

    logic [ntt_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [ntt_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [ntt_pkg::DVS_W-1:0]  dvs_reg;
    logic [ntt_pkg::DCNT_W-1:0] cnt_reg;
    logic                       busy_reg, done_reg;
    logic [ntt_pkg::DVS_W:0]    trial, diff;
    logic                       ge;

    // One restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ntt_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[ntt_pkg::DVS_W-1:0] : trial[ntt_pkg::DVS_W-1:0];
        quo_next = {quo_reg[ntt_pkg::DIV_W-2:0], ge};
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ntt_pkg::DCNT_W'(ntt_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/ntt_back.sv
module ntt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    bpm,
    input  logic [15:0]    tpb,
    input  logic           job_valid,
    input  ntt_pkg::job_t  job,
    output logic           pop,
    output logic           tone_valid,
    input  logic           tone_ready,
    output ntt_pkg::tone_t tone
);

    ntt_pkg::back_state_t state_reg, state_next;
    ntt_pkg::div_req_t    div_req;
    logic                      div_done;
    logic [ntt_pkg::DIV_W-1:0] div_q;

    ntt_pkg::job_t  job_reg;
    logic [15:0]    q_reg, mpt_reg;
    logic [19:0]    freq_reg;
    logic [23:0]    prod_reg, dur;
    ntt_pkg::tone_t tone_reg;
    logic           tone_valid_reg;
    logic           emit;

    ntt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntt_pkg::BK_IDLE: if (job_valid) state_next = ntt_pkg::BK_L1;
            ntt_pkg::BK_L1:   state_next = ntt_pkg::BK_W1;
            ntt_pkg::BK_W1:   if (div_done) state_next = ntt_pkg::BK_L2;
            ntt_pkg::BK_L2:   state_next = ntt_pkg::BK_W2;
            ntt_pkg::BK_W2:
                if (div_done)
                    state_next = job_reg.tone_on ? ntt_pkg::BK_L3 : ntt_pkg::BK_MUL;
            ntt_pkg::BK_L3:   state_next = ntt_pkg::BK_W3;
            ntt_pkg::BK_W3:   if (div_done) state_next = ntt_pkg::BK_MUL;
            ntt_pkg::BK_MUL:  state_next = ntt_pkg::BK_EMIT;
            ntt_pkg::BK_EMIT: if (!tone_valid_reg || tone_ready) state_next = ntt_pkg::BK_IDLE;
            default:          state_next = ntt_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        div_req = '0;
        pop     = 1'b0;
        emit    = 1'b0;
        case (state_reg)
            ntt_pkg::BK_IDLE: pop = job_valid;
            ntt_pkg::BK_L1:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ntt_pkg::MS_PER_MIN;
                div_req.divisor  = {1'b0, bpm};
            end
            ntt_pkg::BK_L2:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {4'b0000, q_reg};
                div_req.divisor  = {1'b0, tpb};
            end
            ntt_pkg::BK_L3:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ntt_pkg::US_PER_S;
                div_req.divisor  = job_reg.period_us;
            end
            ntt_pkg::BK_EMIT: emit = !tone_valid_reg || tone_ready;
            default: ;
        endcase
    end

    // Subtract articulation, floor at ten
    assign dur = (prod_reg < ntt_pkg::SHORT_MS) ? ntt_pkg::ARTIC_MS : prod_reg - ntt_pkg::ARTIC_MS;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= job;
            freq_reg <= '0;
        end
        if (div_done && state_reg == ntt_pkg::BK_W1)
            q_reg <= div_q[15:0];
        if (div_done && state_reg == ntt_pkg::BK_W2)
            mpt_reg <= div_q[15:0];
        if (div_done && state_reg == ntt_pkg::BK_W3)
            freq_reg <= div_q;
        if (state_reg == ntt_pkg::BK_MUL)
            prod_reg <= {8'd0, mpt_reg} * {16'd0, job_reg.length};
        if (emit)
        begin
            tone_reg.tone_on      <= job_reg.tone_on;
            tone_reg.period_us    <= job_reg.period_us;
            tone_reg.frequency_hz <= freq_reg;
            tone_reg.duration_ms  <= dur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ntt_pkg::BK_IDLE;
            tone_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                tone_valid_reg <= 1'b1;
            else if (tone_ready)
                tone_valid_reg <= 1'b0;
        end
    end

    assign tone_valid = tone_valid_reg;
    assign tone       = tone_reg;

endmodule

FILE: rtl/note_token_to_tone.sv
// The back takes one item at a time, paced by the shared 20-step divider
// (tempo, ticks per beat and frequency quotients run through it one after another;
// a rest skips the frequency quotient).
// Parsing and octave/length tracking finish in the accept cycle; a two-item queue
// lets the front keep accepting while the back works or a result waits.
// Reset (rst_n low, asynchronous): tempo 120, ticks 4, octave 4, length 4, queue empty.
module note_token_to_tone (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            token_valid,
    output logic            token_ready,
    input  ntt_pkg::token_t token,
    output logic            tone_valid,
    input  logic            tone_ready,
    output ntt_pkg::tone_t  tone,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [15:0]   bpm_reg, tpb_reg;
    logic          cfg_write;
    logic          push, queue_full, job_valid, pop;
    ntt_pkg::job_t job_in, job_out;

    // APB: zero-wait, write lands in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            ntt_pkg::REG_BPM: prdata = {16'd0, bpm_reg};
            ntt_pkg::REG_TPB: prdata = {16'd0, tpb_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Drop writes of zero: tempo and ticks must stay nonzero for the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg <= ntt_pkg::BPM_RESET;
            tpb_reg <= ntt_pkg::TPB_RESET;
        end
        else if (cfg_write && pwdata[15:0] != 16'd0)
        begin
            case (paddr[2])
                ntt_pkg::REG_BPM: bpm_reg <= pwdata[15:0];
                ntt_pkg::REG_TPB: tpb_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Front: parse the token, track octave and length, hand a job to the queue
    ntt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token),
        .queue_full  (queue_full),
        .push        (push),
        .job         (job_in)
    );

    // Decouple parsing from the slow arithmetic
    ntt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (queue_full),
        .valid   (job_valid),
        .pop     (pop),
        .job_out (job_out)
    );

    // Back: ms per tick, frequency, note time; holds the result until taken
    ntt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bpm        (bpm_reg),
        .tpb        (tpb_reg),
        .job_valid  (job_valid),
        .job        (job_out),
        .pop        (pop),
        .tone_valid (tone_valid),
        .tone_ready (tone_ready),
        .tone       (tone)
    );

`ifndef NO_ASSERTIONS
    a_tone_period: assert property (@(posedge clk) disable iff (!rst_n)
        tone_valid && tone.tone_on |-> tone.period_us != 17'd0 && tone.frequency_hz != 20'd0)
        else $error("tone result with zero period or frequency");

    a_rest_silent: assert property (@(posedge clk) disable iff (!rst_n)
        tone_valid && !tone.tone_on |-> tone.period_us == 17'd0 && tone.frequency_hz == 20'd0)
        else $error("rest result carries a period or frequency");

    a_dur_floor: assert property (@(posedge clk) disable iff (!rst_n)
        tone_valid |-> tone.duration_ms >= ntt_pkg::ARTIC_MS)
        else $error("note time below floor");

    a_cfg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        bpm_reg != 16'd0 && tpb_reg != 16'd0)
        else $error("tempo or ticks register is zero");
`endif

endmodule

FILE: tb/note_token_to_tone_tb.sv
module note_token_to_tone_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run length guard
    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          RANDOM_PER_PHASE = 190;
    localparam int          PHASE_COUNT      = 7;
    localparam int          DRAIN_CYCLES     = 100;
    localparam int          PRINT_CAP        = 40;

    // Token characters used to build stimulus
    localparam logic [7:0]  CH_UPPER_A    = 8'h41;
    localparam logic [7:0]  CH_LOWER_A    = 8'h61;
    localparam logic [7:0]  CH_PAST_G     = 8'h48;
    localparam logic [7:0]  CH_REST_UPPER = 8'h52;
    localparam logic [7:0]  CH_REST_LOWER = 8'h72;
    localparam logic [7:0]  CH_DIGIT0     = 8'h30;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            token_valid = 1'b0;
    logic            token_ready;
    ntt_pkg::token_t token = '0;
    logic            tone_valid;
    logic            tone_ready = 1'b0;
    ntt_pkg::tone_t  tone;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    // Mirror of the block: registers and remembered octave/length
    logic [15:0] bpm_now = ntt_pkg::BPM_RESET;
    logic [15:0] tpb_now = ntt_pkg::TPB_RESET;
    logic [3:0]  octave_now = ntt_pkg::OCT_RESET;
    logic [7:0]  length_now = ntt_pkg::LEN_RESET;

    ntt_pkg::token_t pending_tokens [$];
    ntt_pkg::tone_t  expected_tones [$];
    ntt_pkg::tone_t  want;

    bit          token_taken = 1'b0;
    bit          pacing_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned tones_played = 0;
    int unsigned rests_played = 0;

    note_token_to_tone dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token),
        .tone_valid  (tone_valid),
        .tone_ready  (tone_ready),
        .tone        (tone),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one
    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    // Mostly no pause, sometimes a short one, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!pacing_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build a token from a text; bytes past the text are random filler
    function automatic ntt_pkg::token_t mk(input string s, input bit fresh);
        logic [0:5][7:0] b;
        b = 48'({$urandom, $urandom});
        for (int k = 0; k < s.len(); k++)
            b[k] = s[k];
        return ntt_pkg::token_t'({b, 3'(s.len()), fresh});
    endfunction

    // Parse one token against the mirrored state and work out its tone.
    // Advances the remembered octave and length exactly as the block does.
    function automatic ntt_pkg::tone_t tone_for_token(input ntt_pkg::token_t t);
        logic [0:5][7:0] text;
        int unsigned     count;
        int unsigned     at;
        logic [7:0]      note;
        int              shift;
        bit              raised;
        int unsigned     base;
        int unsigned     alt;
        int unsigned     period;
        int unsigned     digits;
        int unsigned     ms_tick;
        int unsigned     total;
        int unsigned     held;
        ntt_pkg::tone_t  res;

        text   = {t.char0, t.char1, t.char2, t.char3, t.char4, t.char5};
        count  = (t.token_length > 3'd6) ? 6 : int'(t.token_length);
        at     = 1;
        shift  = 0;
        raised = 1'b0;
        res    = '0;

        if (t.restart)
        begin
            octave_now = ntt_pkg::OCT_RESET;
            length_now = ntt_pkg::LEN_RESET;
        end

        // Low five bits 1..7 (A..G) map to 0..6; any other value gives a rest, zero by wrapping
        note = {3'b000, t.char0[4:0]} - 8'd1;

        // Accidental: a flat becomes the sharp of the letter below, Cb drops an octave
        if (at < count && (text[at] == ntt_pkg::CH_SHARP || text[at] == ntt_pkg::CH_FLAT))
        begin
            if (text[at] == ntt_pkg::CH_FLAT)
            begin
                note = (note == 8'd0) ? 8'd6 : note - 8'd1;
                if (note == 8'd1)
                    shift = -1;
            end
            raised = 1'b1;
            at++;
        end

        if (at < count && text[at] != ntt_pkg::CH_COLON)
        begin
            octave_now = text[at][3:0];
            at++;
        end
        shift += int'(octave_now) - 4;

        // Duration: a colon with no digit leaves the length alone
        if (at < count && text[at] == ntt_pkg::CH_COLON)
        begin
            at++;
            if (at < count)
            begin
                digits = text[at][3:0];
                at++;
                if (at < count)
                    digits = digits * 10 + text[at][3:0];
                length_now = 8'(digits);
            end
        end

        if (note < 8'd7)
        begin
            case (note[2:0])
                3'd0:    begin base = 2273; alt = 2145; end
                3'd1:    begin base = 2025; alt = 0;    end
                3'd2:    begin base = 3822; alt = 3608; end
                3'd3:    begin base = 3405; alt = 3214; end
                3'd4:    begin base = 3034; alt = 0;    end
                3'd5:    begin base = 2863; alt = 2703; end
                default: begin base = 2551; alt = 2408; end
            endcase
            // B and E have no sharp slot: keep the natural period
            if (raised && alt != 0)
                base = alt;
            period = (shift >= 0) ? (base >> shift) : (base << (-shift));
            if (period == 0)
                period = 1;
            res.tone_on      = 1'b1;
            res.period_us    = 17'(period);
            res.frequency_hz = 20'(1000000 / period);
            tones_played++;
        end
        else
            rests_played++;

        ms_tick = (60000 / bpm_now) / tpb_now;
        total   = ms_tick * length_now;
        held    = (total < 20) ? 10 : total - 10;
        if (held > 32'hffffff)
            held = 32'hffffff;
        res.duration_ms = 24'(held);
        return res;
    endfunction

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // A zero tempo or tick count is dropped by the block
        if (val[15:0] != 16'd0)
        begin
            if (idx == ntt_pkg::REG_BPM)
                bpm_now = val[15:0];
            else
                tpb_now = val[15:0];
        end
    endtask

    // Register read, compared with the mirror
    task automatic reg_check(input logic idx, input logic [15:0] expected_value);
        logic [31:0] got;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== {16'd0, expected_value})
            report($sformatf("register %0d read %0h, expected %0h", idx, got, expected_value));
    endtask

    // Token driver: hold valid and payload until taken, then pause or advance
    always @(negedge clk)
    begin
        logic next_valid;
        if (!token_valid || token_taken)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                next_valid = 1'b0;
            end
            else if (pending_tokens.size() != 0)
            begin
                token <= pending_tokens.pop_front();
                next_valid = 1'b1;
                send_gap = pick_gap();
            end
            else
                next_valid = 1'b0;
            token_valid <= next_valid;
        end
        token_taken = 1'b0;
    end

    // Result side back-pressure: drop ready for a random stretch now and then
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            tone_ready <= 1'b0;
        end
        else
        begin
            tone_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Monitor: predict on each accepted token, check each accepted tone
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_valid && token_ready)
            begin
                expected_tones.push_back(tone_for_token(token));
                token_taken = 1'b1;
                items_sent++;
            end
            if (tone_valid && tone_ready)
            begin
                results_checked++;
                if (expected_tones.size() == 0)
                    report("result with nothing pending");
                else
                begin
                    want = expected_tones.pop_front();
                    if (tone.tone_on !== want.tone_on)
                        report($sformatf("tone_on %0b, expected %0b",
                                         tone.tone_on, want.tone_on));
                    if (tone.period_us !== want.period_us)
                        report($sformatf("period_us %0d, expected %0d",
                                         tone.period_us, want.period_us));
                    if (tone.frequency_hz !== want.frequency_hz)
                        report($sformatf("frequency_hz %0d, expected %0d",
                                         tone.frequency_hz, want.frequency_hz));
                    if (tone.duration_ms !== want.duration_ms)
                        report($sformatf("duration_ms %0d, expected %0d",
                                         tone.duration_ms, want.duration_ms));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_tones.size());
            $display("note_token_to_tone: mismatch");
            $finish;
        end
    end

    initial
    begin
        ntt_pkg::token_t t;
        logic [0:5][7:0] b;
        int unsigned     n;
        int unsigned     pick;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // Block is idle here: change the tempo setup for this phase
            case (phase)
                0:
                begin
                    // Reset values, then directed tokens at default tempo
                    pending_tokens.push_back(mk("A4", 1'b1));
                    pending_tokens.push_back(mk("B", 1'b0));
                    pending_tokens.push_back(mk("C#5:8", 1'b0));
                    // flat turns into the sharp of the letter below
                    pending_tokens.push_back(mk("Db", 1'b0));
                    // C flat: becomes B and drops an octave
                    pending_tokens.push_back(mk("Cb4:16", 1'b0));
                    // A flat wraps around to G sharp
                    pending_tokens.push_back(mk("Ab3", 1'b0));
                    // sharps with no table slot fall back to the natural period; then F# at octave 0, length 99
                    pending_tokens.push_back(mk("E#", 1'b0));
                    pending_tokens.push_back(mk("B#6", 1'b0));
                    pending_tokens.push_back(mk("F#0:99", 1'b0));
                    // top octave: periods shift down to 1, or to 0 and saturate
                    pending_tokens.push_back(mk("G?", 1'b0));
                    pending_tokens.push_back(mk("B?", 1'b0));
                    // longest period: C flat at octave 0
                    pending_tokens.push_back(mk("Cb0", 1'b0));
                    pending_tokens.push_back(mk("C0", 1'b0));
                    // rests: r, R, letters past G, odd bytes
                    pending_tokens.push_back(mk("r:2", 1'b0));
                    pending_tokens.push_back(mk("R", 1'b0));
                    pending_tokens.push_back(mk("H3", 1'b0));
                    pending_tokens.push_back(mk("z", 1'b0));
                    pending_tokens.push_back(mk("@", 1'b0));
                    // colon with no digits keeps the length; zero length hits the floor
                    pending_tokens.push_back(mk("E:", 1'b0));
                    pending_tokens.push_back(mk("D:0", 1'b0));
                    pending_tokens.push_back(mk("g2:1", 1'b0));
                    // token length zero reads only the letter
                    t = mk("A#7:12", 1'b0);
                    t.token_length = 3'd0;
                    pending_tokens.push_back(t);
                    // token length seven counts as six
                    t = mk("C#2:45", 1'b0);
                    t.token_length = 3'd7;
                    pending_tokens.push_back(t);
                    // letter byte all zeros and all ones
                    t = mk("x4", 1'b0);
                    t.char0 = 8'h00;
                    pending_tokens.push_back(t);
                    t = mk("x:3", 1'b0);
                    t.char0 = 8'hff;
                    pending_tokens.push_back(t);
                    // restart returns octave and length to 4
                    pending_tokens.push_back(mk("C", 1'b1));
                end
                1:
                begin
                    reg_write(ntt_pkg::REG_BPM, 32'd1);
                    reg_write(ntt_pkg::REG_TPB, 32'd1);
                end
                2:
                begin
                    reg_write(ntt_pkg::REG_BPM, 32'd65535);
                    reg_write(ntt_pkg::REG_TPB, 32'd65535);
                end
                3:
                    reg_write(ntt_pkg::REG_TPB, 32'd1);
                4:
                begin
                    // zero writes must leave both registers alone
                    reg_write(ntt_pkg::REG_BPM, 32'd97);
                    reg_write(ntt_pkg::REG_BPM, 32'd0);
                    reg_write(ntt_pkg::REG_TPB, 32'd0);
                end
                5:
                begin
                    reg_write(ntt_pkg::REG_BPM, 32'($urandom_range(30, 400)));
                    reg_write(ntt_pkg::REG_TPB, 32'($urandom_range(1, 12)));
                end
                default:
                begin
                    reg_write(ntt_pkg::REG_BPM, 32'($urandom_range(1, 65535)));
                    reg_write(ntt_pkg::REG_TPB, 32'($urandom_range(1, 4)));
                end
            endcase
            reg_check(ntt_pkg::REG_BPM, bpm_now);
            reg_check(ntt_pkg::REG_TPB, tpb_now);

            // One phase runs without any pauses on either side
            pacing_on = (phase != 2);

            repeat (RANDOM_PER_PHASE)
            begin
                b = 48'({$urandom, $urandom});
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // well-formed: letter, accidental, octave, colon and digits
                    pick = $urandom_range(0, 15);
                    if (pick < 7)
                        b[0] = 8'(CH_UPPER_A + pick);
                    else if (pick < 14)
                        b[0] = 8'(CH_LOWER_A + pick - 7);
                    else if (pick == 14)
                        b[0] = $urandom_range(0, 1) ? CH_REST_LOWER : CH_REST_UPPER;
                    else
                        b[0] = 8'(CH_PAST_G + $urandom_range(0, 18));
                    n = 1;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        b[n] = $urandom_range(0, 1) ? ntt_pkg::CH_SHARP : ntt_pkg::CH_FLAT;
                        n++;
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        b[n] = 8'(CH_DIGIT0 + $urandom_range(0, 9));
                        n++;
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        b[n] = ntt_pkg::CH_COLON;
                        n++;
                        repeat ($urandom_range(0, 2))
                        begin
                            b[n] = 8'(CH_DIGIT0 + $urandom_range(0, 15));
                            n++;
                        end
                    end
                    // now and then cut the token short or claim extra bytes
                    if ($urandom_range(0, 7) == 0)
                        n = $urandom_range(0, 7);
                end
                else
                    n = $urandom_range(0, 7);
                pending_tokens.push_back(
                    ntt_pkg::token_t'({b, 3'(n), 1'($urandom_range(0, 9) == 0)}));
            end

            // Wait for every token taken and every tone returned
            while (pending_tokens.size() != 0 || token_valid || expected_tones.size() != 0)
                @(posedge clk);
        end

        // Let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d tokens (%0d tones, %0d rests) over %0d tempo setups",
                 items_sent, tones_played, rests_played, PHASE_COUNT);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("note_token_to_tone: match");
        else
            $display("note_token_to_tone: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ntt_pkg.sv
rtl/ntt_front.sv
rtl/ntt_queue.sv
rtl/ntt_divider.sv
rtl/ntt_back.sv
rtl/note_token_to_tone.sv
tb/note_token_to_tone_tb.sv
